// ----- design/scrt_pkg.sv -----
// Package for the subnet connection rate tracker: payload structs, register
// indexes, sizes and the divider handshake struct. No dependencies.
package scrt_pkg;

	localparam int unsigned Entries   = 64;
	localparam int unsigned IdxBits   = $clog2(Entries);
	localparam int unsigned CountBits = 16;
	localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
	localparam logic [5:0] NetPrefixLen  = 6'd24;
	localparam logic [5:0] HostPrefixLen = 6'd32;

	localparam logic [2:0] RegMaxIdle    = 3'd0;
	localparam logic [2:0] RegReportCnt  = 3'd1;
	localparam logic [2:0] RegBlockCnt   = 3'd2;
	localparam logic [2:0] RegMaxMean    = 3'd3;
	localparam logic [2:0] RegEnforce    = 3'd4;
	localparam logic [2:0] RegExPrefix   = 3'd5;
	localparam logic [2:0] RegExFirst    = 3'd6;
	localparam logic [2:0] RegExLast     = 3'd7;

	localparam logic [1:0] ActNone  = 2'd0;
	localparam logic [1:0] ActShape = 2'd1;
	localparam logic [1:0] ActNull  = 2'd2;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic        exempted;
		logic        entry_hit;
		logic        table_full;
		logic [15:0] connection_count;
		logic [31:0] mean_interval;
		logic        report;
		logic [1:0]  block_action;
		logic        block_detected;
		logic [5:0]  block_prefix_length;
		logic [31:0] block_address;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [31:0]          dividend;
		logic [CountBits-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [CountBits-1:0] count;
		logic [31:0]          start_time;
		logic [31:0]          last_seen;
		logic [7:0]           first_host;
		logic                 multi_host;
		logic [23:0]          prefix;
	} entry_t;

endpackage

// ----- design/scrt_div.sv -----
// Restoring divider, one quotient bit a cycle.
// Depends on scrt_pkg.
module scrt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  scrt_pkg::div_req_t req,
	output scrt_pkg::div_rsp_t rsp
);
	logic [31:0] quo_q;
	logic [scrt_pkg::CountBits:0] rem_q;
	logic [scrt_pkg::CountBits-1:0] den_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [scrt_pkg::CountBits:0] trial;
	logic [scrt_pkg::CountBits:0] diff;

	assign trial = {rem_q[scrt_pkg::CountBits-1:0], quo_q[31]};
	assign diff  = trial - {1'b0, den_q};

	// shift in one dividend bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[scrt_pkg::CountBits]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

// ----- design/subnet_connection_rate_tracker_top.sv -----
// Subnet connection rate tracker, top level. Holds the entry memory, the
// scan sequencer and the registers. Depends on scrt_pkg and scrt_div.
//
// Use: send one connection request (source address, time in seconds) on the
// in channel; one result request follows on the out channel. The user writes
// registers through the cfg channel (index, data) only while the block is idle;
// the block does not enforce this. Timing: an exempt source skips the table
// walk. Others scan the 64 entry table one entry a cycle through a single
// read port memory with a registered read, expiring stale entries and finding
// the match and the lowest free entry; a hit then runs the serial divider for
// the mean interval.
// One request is in work at a time; the next is taken from the cycle after
// the result has been accepted.
// Reset: valid bits clear at once, registers take their reset values; no
// clearing pass. A stalled receiver holds the result in the output
// register, and no new request is taken until that result is accepted.
module subnet_connection_rate_tracker_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scrt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output scrt_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DEC   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_DONE  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam int unsigned IB = scrt_pkg::IdxBits;

	state_t state_q;
	logic [15:0] max_idle_q, report_cnt_q, block_cnt_q, max_mean_q, ex_prefix_q;
	logic [1:0]  enforce_q;
	logic [7:0]  ex_first_q, ex_last_q;

	scrt_pkg::in_item_t  item_q;
	scrt_pkg::out_item_t res_q;
	logic                res_valid_q;

	// entry memory and valid bits
	scrt_pkg::entry_t mem [scrt_pkg::Entries];
	scrt_pkg::entry_t rd_s1;
	logic [scrt_pkg::Entries-1:0] valid_q;
	logic [IB:0] addr_q;
	logic [IB-1:0] rd_idx_s1;
	logic rd_vld_s1;
	logic we;
	logic [IB-1:0] wr_idx;
	scrt_pkg::entry_t wr_data;

	logic hit_q, free_q;
	logic [IB-1:0] hit_idx_q, free_idx_q;
	scrt_pkg::entry_t hit_ent_q;

	scrt_pkg::div_req_t div_req;
	scrt_pkg::div_rsp_t div_rsp;

	scrt_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// exemption check
	logic [7:0] third;
	logic exempt;
	always_comb begin
		third = item_q.source_address[15:8];
		exempt = 1'b0;
		if (ex_prefix_q != 16'd0 && item_q.source_address[31:16] == ex_prefix_q) begin
			if (ex_last_q > ex_first_q) exempt = third >= ex_first_q && third <= ex_last_q;
			else exempt = third == ex_first_q;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// entry read port
	always_ff @(posedge clk) begin
		rd_s1 <= mem[addr_q[IB-1:0]];
		if (we) mem[wr_idx] <= wr_data;
	end

	// check of the entry read last cycle
	logic live;
	logic [31:0] idle;
	assign idle = item_q.now_seconds - rd_s1.last_seen;
	assign live = valid_q[rd_idx_s1] && !(idle > {16'd0, max_idle_q});

	// updated entry on a hit
	scrt_pkg::entry_t upd;
	logic [scrt_pkg::CountBits-1:0] new_cnt;
	assign new_cnt = (hit_ent_q.count < scrt_pkg::CountMax) ?
		hit_ent_q.count + 1'b1 : hit_ent_q.count;
	always_comb begin
		upd = hit_ent_q;
		upd.count = new_cnt;
		upd.last_seen = item_q.now_seconds;
		if (item_q.source_address[7:0] != hit_ent_q.first_host) upd.multi_host = 1'b1;
	end

	always_comb begin
		we = 1'b0;
		wr_idx = hit_idx_q;
		wr_data = upd;
		div_req.start = 1'b0;
		div_req.dividend = item_q.now_seconds - hit_ent_q.start_time;
		div_req.divisor = new_cnt;
		if (state_q == ST_DEC) begin
			if (hit_q) begin
				we = 1'b1;
				div_req.start = 1'b1;
			end else if (free_q) begin
				we = 1'b1;
				wr_idx = free_idx_q;
				wr_data.count = '0;
				wr_data.count[0] = 1'b1;
				wr_data.start_time = item_q.now_seconds;
				wr_data.last_seen = item_q.now_seconds;
				wr_data.first_host = item_q.source_address[7:0];
				wr_data.multi_host = 1'b0;
				wr_data.prefix = item_q.source_address[31:8];
			end
		end
	end

	// result for an exempt source and for a miss
	scrt_pkg::out_item_t ex_res, miss_res;
	always_comb begin
		ex_res = '0;
		ex_res.exempted = 1'b1;
		miss_res = '0;
		if (free_q) miss_res.connection_count = 16'd1;
		else miss_res.table_full = 1'b1;
	end

	// result build after division
	scrt_pkg::out_item_t hit_res;
	logic rep, blk;
	always_comb begin
		rep = {16'd0, report_cnt_q} <= 32'(new_cnt) &&
			div_rsp.quotient <= {16'd0, max_mean_q};
		blk = {16'd0, block_cnt_q} <= 32'(new_cnt) &&
			div_rsp.quotient <= {16'd0, max_mean_q};
		hit_res = '0;
		hit_res.entry_hit = 1'b1;
		hit_res.connection_count = 16'(new_cnt);
		hit_res.mean_interval = div_rsp.quotient;
		hit_res.report = rep;
		if (blk) begin
			hit_res.block_detected = 1'b1;
			hit_res.block_action = enforce_q[0] ? scrt_pkg::ActShape :
				(enforce_q == scrt_pkg::ActNull ? scrt_pkg::ActNull : scrt_pkg::ActNone);
			if (upd.multi_host) begin
				hit_res.block_prefix_length = scrt_pkg::NetPrefixLen;
				hit_res.block_address = {item_q.source_address[31:8], 8'd0};
			end else begin
				hit_res.block_prefix_length = scrt_pkg::HostPrefixLen;
				hit_res.block_address = item_q.source_address;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_idle_q   <= 16'd30;
			report_cnt_q <= 16'd10;
			block_cnt_q  <= 16'd15;
			max_mean_q   <= 16'd4;
			enforce_q    <= 2'd0;
			ex_prefix_q  <= 16'd2560;
			ex_first_q   <= 8'd0;
			ex_last_q    <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scrt_pkg::RegMaxIdle:   max_idle_q   <= cfg_data;
				scrt_pkg::RegReportCnt: report_cnt_q <= cfg_data;
				scrt_pkg::RegBlockCnt:  block_cnt_q  <= cfg_data;
				scrt_pkg::RegMaxMean:   max_mean_q   <= cfg_data;
				scrt_pkg::RegEnforce:   enforce_q    <= cfg_data[1:0];
				scrt_pkg::RegExPrefix:  ex_prefix_q  <= cfg_data;
				scrt_pkg::RegExFirst:   ex_first_q   <= cfg_data[7:0];
				scrt_pkg::RegExLast:    ex_last_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			if (res_valid_q && out_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= ST_SCAN;
						addr_q  <= '0;
						rd_vld_s1 <= 1'b0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (exempt && !rd_vld_s1 && addr_q == '0) begin
						res_q <= ex_res;
						state_q <= ST_OUT;
					end else begin
						// walk entries; previous read is checked now
						rd_vld_s1 <= !addr_q[IB];
						rd_idx_s1 <= addr_q[IB-1:0];
						if (!addr_q[IB]) addr_q <= addr_q + 1'b1;
						if (rd_vld_s1) begin
							if (!live) valid_q[rd_idx_s1] <= 1'b0;
							if (live && !hit_q &&
								rd_s1.prefix == item_q.source_address[31:8]) begin
								hit_q <= 1'b1;
								hit_idx_q <= rd_idx_s1;
								hit_ent_q <= rd_s1;
							end
							if (!live && !free_q) begin
								free_q <= 1'b1;
								free_idx_q <= rd_idx_s1;
							end
						end
						if (addr_q[IB] && !rd_vld_s1) state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (hit_q) state_q <= ST_DIV;
					else begin
						res_q <= miss_res;
						if (free_q) valid_q[free_idx_q] <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						res_q   <= hit_res;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					res_valid_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
